// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only when reset is not active.
`define AST_IMP(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked only when reset is not active.
`define AST_NXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/abst_pkg.sv =====
package abst_pkg;

  localparam int LEVELS_DEF     = 6;
  localparam int VALUE_BITS_DEF = 31;

  localparam int CMD_W   = 3;
  localparam int KEY_W   = 31;
  localparam int STAT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_IN     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PRE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POST   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LEVEL  = 3'd4;

  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOROOM   = 2'd1;
  localparam logic [STAT_W-1:0] ST_ITEM     = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key_value;
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0]  out_value;
    logic [STAT_W-1:0] status;
    logic              last;
  } rsp_t;

endpackage

// ===== rtl/abst_store.sv =====
module abst_store #(
  parameter int LEVELS     = abst_pkg::LEVELS_DEF,
  parameter int VALUE_BITS = abst_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [LEVELS-1:0]         wr_addr,
  input  logic [VALUE_BITS-1:0]     wr_data,
  input  logic [LEVELS-1:0]         rd_addr,
  output logic [VALUE_BITS-1:0]     rd_data,
  output logic [(1<<LEVELS)-2:0]    used
);

  localparam int SLOTS = (1 << LEVELS) - 1;

  // Stored values; an entry is only meaningful once its used bit is set.
  logic [VALUE_BITS-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (wr_en) begin
      used[wr_addr] <= 1'b1;
    end
  end

endmodule

// ===== rtl/array_bst_insert_traverse.sv =====
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | abst_pkg::req_t (cmd, key_value)
// rsp     | out       | rsp_valid/rsp_stall | abst_pkg::rsp_t (out_value, status, last)
//
// One item is processed at a time; req_stall stays high until its last result is queued.
// Insert walks one tree level per step, at most LEVELS levels, with a registered read
// of the value memory at each step down the path.
// Depth-first walks pass each stored node in its enter, mid and exit phases, and level
// order scans every slot; both step once per cycle through the value memory unless stalled.
// Reset clears the slot-used bits at once, so no clearing pass is needed.
// A stalled result output freezes the sequencer in every state but idle until it is taken.
module array_bst_insert_traverse #(
  parameter int LEVELS     = abst_pkg::LEVELS_DEF,
  parameter int VALUE_BITS = abst_pkg::VALUE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  abst_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output abst_pkg::rsp_t rsp
);

  localparam int IW    = LEVELS;
  localparam int SLOTS = (1 << LEVELS) - 1;
  localparam logic [IW:0]   SLOTS_W  = (IW+1)'(SLOTS);
  localparam logic [IW-1:0] LAST_LO  = IW'(SLOTS >> 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_DFS   = 3'd2;
  localparam logic [2:0] S_LVL   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  // Depth-first phases at the current node: just entered, greater side done,
  // both sides done.
  localparam logic [1:0] PH_ENTER = 2'd0;
  localparam logic [1:0] PH_MID   = 2'd1;
  localparam logic [1:0] PH_EXIT  = 2'd2;

  logic [2:0]            state, state_next;
  logic [IW-1:0]         cur, cur_next;
  logic [1:0]            ph, ph_next;
  logic [2:0]            ord;
  logic [VALUE_BITS-1:0] key;
  logic [VALUE_BITS-1:0] pend, pend_next;
  logic                  pend_valid, pend_valid_next;

  logic                  wr_en;
  logic [VALUE_BITS-1:0] rd_data;
  logic [SLOTS-1:0]      used;

  logic                  out_free;
  logic                  push;
  abst_pkg::rsp_t        push_data;

  logic [IW:0]           g_idx, l_idx, ins_child;
  logic [IW+1:0]         lvl_up;
  logic                  g_ok, l_ok, emit;

  // The value memory is addressed with the next node, so rd_data always holds
  // the value of the node the sequencer is currently standing on.
  abst_store #(
    .LEVELS     (LEVELS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (cur),
    .wr_data (key),
    .rd_addr (cur_next),
    .rd_data (rd_data),
    .used    (used)
  );

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  assign g_idx     = {cur, 1'b0} + (IW+1)'(2);
  assign l_idx     = {cur, 1'b0} + (IW+1)'(1);
  assign g_ok      = (g_idx < SLOTS_W) && used[g_idx[IW-1:0]];
  assign l_ok      = (l_idx < SLOTS_W) && used[l_idx[IW-1:0]];
  assign ins_child = (rd_data < key) ? g_idx : l_idx;
  assign lvl_up    = {cur, 2'b00} + (IW+2)'(2);

  // DFS visits emit in the phase matching the order; level scans emit every used slot.
  assign emit = (state == S_LVL) ? used[cur] :
                ((ph == PH_ENTER) && (ord == abst_pkg::CMD_PRE)) ||
                ((ph == PH_MID)   && (ord == abst_pkg::CMD_IN))  ||
                ((ph == PH_EXIT)  && (ord == abst_pkg::CMD_POST));

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    ph_next         = ph;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    push            = 1'b0;
    push_data       = '0;
    wr_en           = 1'b0;

    unique case (state)
      S_IDLE: begin
        cur_next = '0;
        ph_next  = PH_ENTER;
        if (req_valid) begin
          priority if (req.cmd == abst_pkg::CMD_INSERT) begin
            state_next = S_INS;
          end else if (req.cmd == abst_pkg::CMD_LEVEL) begin
            state_next = S_LVL;
          end else if (req.cmd == abst_pkg::CMD_IN || req.cmd == abst_pkg::CMD_PRE ||
                       req.cmd == abst_pkg::CMD_POST) begin
            state_next = S_DFS;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      S_INS: begin
        if (out_free) begin
          if (!used[cur]) begin
            wr_en            = 1'b1;
            push             = 1'b1;
            push_data.status = abst_pkg::ST_INSERTED;
            push_data.last   = 1'b1;
            state_next       = S_IDLE;
          end else if (ins_child >= SLOTS_W) begin
            push             = 1'b1;
            push_data.status = abst_pkg::ST_NOROOM;
            push_data.last   = 1'b1;
            state_next       = S_IDLE;
          end else begin
            cur_next = ins_child[IW-1:0];
          end
        end
      end

      S_DFS, S_LVL: begin
        if (out_free) begin
          if (!used[0]) begin
            push             = 1'b1;
            push_data.status = abst_pkg::ST_EMPTY;
            push_data.last   = 1'b1;
            state_next       = S_IDLE;
          end else begin
            // The newest value is held back one visit so that the final one
            // can carry the last mark.
            if (emit) begin
              if (pend_valid) begin
                push                = 1'b1;
                push_data.out_value = abst_pkg::KEY_W'(pend);
                push_data.status    = abst_pkg::ST_ITEM;
              end
              pend_next       = rd_data;
              pend_valid_next = 1'b1;
            end
            if (state == S_LVL) begin
              // Scan each level from its highest slot down to its lowest.
              if (cur == LAST_LO) begin
                state_next = S_FLUSH;
              end else if ((cur & (cur + IW'(1))) == '0) begin
                cur_next = lvl_up[IW-1:0];
              end else begin
                cur_next = cur - IW'(1);
              end
            end else begin
              unique case (ph)
                PH_ENTER: begin
                  if (g_ok) begin
                    cur_next = g_idx[IW-1:0];
                  end else begin
                    ph_next = PH_MID;
                  end
                end
                PH_MID: begin
                  if (l_ok) begin
                    cur_next = l_idx[IW-1:0];
                    ph_next  = PH_ENTER;
                  end else begin
                    ph_next = PH_EXIT;
                  end
                end
                PH_EXIT: begin
                  if (cur == '0) begin
                    state_next = S_FLUSH;
                  end else begin
                    cur_next = (cur - IW'(1)) >> 1;
                    ph_next  = cur[0] ? PH_EXIT : PH_MID;
                  end
                end
                default: begin
                  ph_next = PH_EXIT;
                end
              endcase
            end
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          push                = 1'b1;
          push_data.out_value = abst_pkg::KEY_W'(pend);
          push_data.status    = abst_pkg::ST_ITEM;
          push_data.last      = 1'b1;
          pend_valid_next     = 1'b0;
          state_next          = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
      cur        <= '0;
      ph         <= PH_ENTER;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
      cur        <= cur_next;
      ph         <= ph_next;
      if (push) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (push) begin
      rsp <= push_data;
    end
    if (state == S_IDLE && req_valid) begin
      ord <= req.cmd;
      key <= VALUE_BITS'(req.key_value);
    end
  end

endmodule

// ===== rtl/abst_checker.sv =====
`include "assert_macros.svh"

module abst_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input abst_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input abst_pkg::rsp_t rsp
);

  logic cmd_taken;
  logic single_rsp;

  assign cmd_taken  = req_valid && !req_stall && (req.cmd <= abst_pkg::CMD_LEVEL);
  assign single_rsp = rsp_valid && (rsp.status != abst_pkg::ST_ITEM);

  // A valid command keeps the block busy until its results are queued.
  `AST_NXT(a_cmd_busy, clk, rst, cmd_taken, req_stall)

  // Insert, no-room and empty answers are always the only result of their item.
  `AST_IMP(a_single_last, clk, rst, single_rsp, rsp.last)

  `AST_IMP(a_zero_value, clk, rst, single_rsp, rsp.out_value == '0)

  `AST_NXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind array_bst_insert_traverse abst_checker u_abst_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ===== tb/sv/array_bst_insert_traverse_tb.sv =====
module array_bst_insert_traverse_tb;

  localparam int NLEV  = abst_pkg::LEVELS_DEF;
  localparam int NSLOT = (1 << NLEV) - 1;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int KEY_W = abst_pkg::KEY_W;
  localparam int CMD_W = abst_pkg::CMD_W;

  // Command codes the block ignores.
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

  // Scoreboard: holds a shadow copy of the tree and the queue of results that
  // each accepted request item is predicted to produce.
  class tree_scoreboard;
    logic [KEY_W-1:0] shadow_value[NSLOT];
    bit               shadow_used[NSLOT];
    abst_pkg::rsp_t   pending[$];
    int               mismatches;

    function new();
      foreach (shadow_used[i]) shadow_used[i] = 0;
      foreach (shadow_value[i]) shadow_value[i] = '0;
      mismatches = 0;
    endfunction

    function bit occupied(int idx);
      return idx < NSLOT && shadow_used[idx];
    endfunction

    function void push_item(logic [KEY_W-1:0] v);
      abst_pkg::rsp_t r;
      r.out_value = v;
      r.status = abst_pkg::ST_ITEM;
      r.last = 1'b0;
      pending.push_back(r);
    endfunction

    // Depth-first walk, greater side first; order holds the traversal command.
    function void walk_tree(int idx, logic [CMD_W-1:0] order);
      if (!occupied(idx)) return;
      if (order == abst_pkg::CMD_PRE) push_item(shadow_value[idx]);
      walk_tree(2 * idx + 2, order);
      if (order == abst_pkg::CMD_IN) push_item(shadow_value[idx]);
      walk_tree(2 * idx + 1, order);
      if (order == abst_pkg::CMD_POST) push_item(shadow_value[idx]);
    endfunction

    function void note_request(abst_pkg::req_t q);
      abst_pkg::rsp_t r;
      int   idx;
      int   fifo[$];
      int   before_n;
      before_n = pending.size();
      r = '0;
      if (q.cmd == abst_pkg::CMD_INSERT) begin
        idx = 0;
        while (idx < NSLOT && shadow_used[idx])
          idx = (shadow_value[idx] < q.key_value) ? 2 * idx + 2 : 2 * idx + 1;
        if (idx < NSLOT) begin
          shadow_value[idx] = q.key_value;
          shadow_used[idx] = 1;
          r.status = abst_pkg::ST_INSERTED;
        end else begin
          r.status = abst_pkg::ST_NOROOM;
        end
        pending.push_back(r);
      end else if (q.cmd <= abst_pkg::CMD_LEVEL) begin
        if (!occupied(0)) begin
          r.status = abst_pkg::ST_EMPTY;
          pending.push_back(r);
        end else if (q.cmd == abst_pkg::CMD_LEVEL) begin
          fifo.push_back(0);
          while (fifo.size() > 0) begin
            idx = fifo.pop_front();
            push_item(shadow_value[idx]);
            if (occupied(2 * idx + 2)) fifo.push_back(2 * idx + 2);
            if (occupied(2 * idx + 1)) fifo.push_back(2 * idx + 1);
          end
        end else begin
          walk_tree(0, q.cmd);
        end
      end
      if (pending.size() > before_n) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_result(abst_pkg::rsp_t got);
      abst_pkg::rsp_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: value=%0d status=%0d last=%0b",
                   got.out_value, got.status, got.last);
        return;
      end
      want = pending.pop_front();
      if (got.out_value !== want.out_value || got.status !== want.status ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected value=%0d status=%0d last=%0b, ",
                    "got value=%0d status=%0d last=%0b"},
                   want.out_value, want.status, want.last,
                   got.out_value, got.status, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  abst_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall;
  abst_pkg::rsp_t rsp;

  tree_scoreboard sb;

  // Idle rates in percent; the receiver can also be held for a long stretch.
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  recv_hold;
  int  quiet_cycles;

  array_bst_insert_traverse i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: decides the stall for the next cycle at each rising edge.
  initial begin
    rsp_stall = 1'b1;
    forever begin
      @(posedge clk);
      if (recv_hold)
        rsp_stall <= 1'b1;
      else
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result monitor and the watchdog on cycles without any accepted item.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (rsp_valid && !rsp_stall) sb.check_result(rsp);
        if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
          quiet_cycles = 0;
        else
          quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // Offers one item and holds it until the block takes it. Idle cycles
  // are inserted ahead of the item at the current sender idle rate. The
  // valid stays high after acceptance until the next call or drain() drives
  // it in the same time step.
  task automatic send_item(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k);
    abst_pkg::req_t q;
    q.cmd = c;
    q.key_value = k;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= q;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(q);
  endtask

  // Waits until every predicted result has come back, then lets the block
  // settle after items that produce nothing.
  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(int spread);
    case ($urandom_range(5))
      0: return '0;
      1: return {KEY_W{1'b1}};
      2: return KEY_W'($urandom);
      default: return KEY_W'($urandom_range(spread));
    endcase
  endfunction

  // Random phase: the tree is never cleared, so inserts mostly land on a
  // full path once the tree grows; traversals and unused codes are mixed in.
  task automatic random_phase(int count);
    int   pick;
    logic [CMD_W-1:0] c;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 60)      c = abst_pkg::CMD_INSERT;
      else if (pick < 67) c = abst_pkg::CMD_IN;
      else if (pick < 74) c = abst_pkg::CMD_PRE;
      else if (pick < 81) c = abst_pkg::CMD_POST;
      else if (pick < 92) c = abst_pkg::CMD_LEVEL;
      else c = CMD_W'($urandom_range(int'(CMD_SPARE_C), int'(CMD_SPARE_A)));
      send_item(c, pick_key(1000));
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b0;
    req_valid = 1'b0;
    req = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty tree on every traversal, unused commands,
    // equal keys going to the less-or-equal side, extreme keys, and a
    // degenerate chain that runs off the bottom of the array.
    send_item(abst_pkg::CMD_IN, '0);
    send_item(abst_pkg::CMD_PRE, '0);
    send_item(abst_pkg::CMD_POST, '0);
    send_item(abst_pkg::CMD_LEVEL, '0);
    send_item(CMD_SPARE_C, {KEY_W{1'b1}});
    send_item(abst_pkg::CMD_INSERT, 31'd500);
    send_item(abst_pkg::CMD_INSERT, 31'd500);
    send_item(abst_pkg::CMD_INSERT, '0);
    send_item(abst_pkg::CMD_INSERT, {KEY_W{1'b1}});
    send_item(abst_pkg::CMD_INSERT, 31'd700);
    send_item(abst_pkg::CMD_IN, '0);
    send_item(abst_pkg::CMD_PRE, '0);
    send_item(abst_pkg::CMD_POST, '0);
    send_item(abst_pkg::CMD_LEVEL, '0);
    for (int i = 0; i < 5; i++) send_item(abst_pkg::CMD_INSERT, {KEY_W{1'b1}});
    send_item(abst_pkg::CMD_INSERT, {KEY_W{1'b1}});
    send_item(CMD_SPARE_A, 31'd3);
    send_item(CMD_SPARE_B, 31'd3);
    send_item(abst_pkg::CMD_LEVEL, '0);

    // Sender pauses until every expected result has come back.
    drain();

    // Long receiver hold while the sender keeps offering traversals and an insert.
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
      begin
        send_item(abst_pkg::CMD_LEVEL, '0);
        send_item(abst_pkg::CMD_IN, '0);
        send_item(abst_pkg::CMD_INSERT, 31'd1);
      end
    join
    drain();

    send_idle_pct = 21;
    recv_idle_pct = 83;
    random_phase(100);
    drain();

    send_idle_pct = 83;
    recv_idle_pct = 21;
    random_phase(100);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(105);
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
